/* sv/i2cbe_pkg.sv */
// Package for the I2C master bit engine: command codes, sequencer state and
// result types shared by the sequencer step and the top level.
// No dependencies.
package i2cbe_pkg;

  localparam int unsigned TIMEOUT_RESET = 5;
  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned LAST_PHASE    = 8;
  localparam int unsigned PHASE_W       = 4;
  localparam int unsigned BITCNT_W      = 4;
  localparam int unsigned IN_TDATA_W    = 16;
  localparam int unsigned OUT_TDATA_W   = 16;
  localparam int unsigned CFG_ADDR_W    = 3;
  localparam int unsigned CFG_DATA_W    = 32;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  // Register index of ack_timeout on the configuration port.
  localparam logic REG_ACK_TIMEOUT = 1'b0;

  typedef struct packed {
    logic [PHASE_W-1:0]  phase;
    logic [BITCNT_W-1:0] bit_count;
    logic [7:0]          shift_byte;
    cmd_t                active;
    logic                nack_choice;
    logic [7:0]          polls_left;
    logic                scl;
    logic                sda_drive;
    logic                sda_level;
    logic                error;
  } seq_state_t;

  typedef struct packed {
    logic       ack_error;
    logic [7:0] read_data;
    logic       done;
    logic       busy;
    logic       sda_level;
    logic       sda_drive;
    logic       scl_level;
  } result_t;

endpackage

/* sv/i2c_master_bit_engine_unit.sv */
// Top level of the I2C master bit engine: stream ports, configuration
// register, sequencer state register and output register.
// Depends on i2cbe_pkg and i2cbe_seq.

// Each input word is one prescaler tick carrying the sampled SDA level and an
// optional command (start, stop, write byte, read byte with ACK or NACK). The
// engine answers every tick with exactly one output word giving the SCL level,
// the SDA drive enable and level, busy, a done pulse, the shift register
// contents (the received byte on the done word of a read) and the ack-error
// flag. One word is accepted per clock cycle unless the output stalls: the
// sequencer step is a single short pass of logic from the state register to
// the next state. The result is written into the output register at the edge
// that accepts the word and is offered on the output from the next cycle on.
// The output register takes the next word in the same cycle that its current
// word leaves, so the input only stalls when the output register is full and
// the downstream side is not taking it. Commands given while busy, and unknown
// command codes, are ignored. ack_timeout (register 0, byte address 0,
// reset value 5) sets how many ticks the engine polls for the slave ACK after a
// write; zero counts as one poll. On a timeout the engine runs a stop sequence
// and reports the error together with done at the end of that stop. Write the
// register only while the engine is idle.
module i2c_master_bit_engine_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: write_data[7:0], send_nack[8], sda_in[9], zero fill [15:10]
  input  logic [i2cbe_pkg::IN_TDATA_W-1:0]   in_tdata,
  // in_tuser: command[2:0]
  input  logic [2:0]                         in_tuser,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // out_tdata: scl_level[0], sda_drive[1], sda_level[2], busy_res[3],
  // done_res[4], read_data[12:5], ack_error[13], zero fill [15:14]
  output logic [i2cbe_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [i2cbe_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [i2cbe_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [i2cbe_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                               cfg_pready
);

  localparam int unsigned PadW = i2cbe_pkg::OUT_TDATA_W - $bits(i2cbe_pkg::result_t);

  i2cbe_pkg::seq_state_t state_r;
  i2cbe_pkg::seq_state_t state_nxt;
  i2cbe_pkg::result_t    result;
  logic [7:0]            ack_timeout_r;
  logic [i2cbe_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic                  out_valid_r;
  logic                  in_fire;
  logic                  cfg_write;

  // APB: every access completes without wait states. The register index is
  // paddr[2]; only index 0 exists.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == i2cbe_pkg::REG_ACK_TIMEOUT)
                      ? {{(i2cbe_pkg::CFG_DATA_W-8){1'b0}}, ack_timeout_r}
                      : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r <= 8'(i2cbe_pkg::TIMEOUT_RESET);
    end else if (cfg_write && cfg_paddr[2] == i2cbe_pkg::REG_ACK_TIMEOUT) begin
      ack_timeout_r <= cfg_pwdata[7:0];
    end
  end

  // The input side is open whenever the output register is empty or is being
  // emptied in this cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  i2cbe_seq u_seq (
    .state_cur   (state_r),
    .command     (in_tuser),
    .write_data  (in_tdata[7:0]),
    .send_nack   (in_tdata[8]),
    .sda_in      (in_tdata[9]),
    .ack_timeout (ack_timeout_r),
    .state_nxt   (state_nxt),
    .result      (result)
  );

  // Sequencer state only moves on an accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= '0;
      state_r.bit_count   <= '0;
      state_r.shift_byte  <= '0;
      state_r.active      <= i2cbe_pkg::CMD_NONE;
      state_r.nack_choice <= 1'b0;
      state_r.polls_left  <= '0;
      state_r.scl         <= 1'b1;
      state_r.sda_drive   <= 1'b1;
      state_r.sda_level   <= 1'b1;
      state_r.error       <= 1'b0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_tdata_r <= {{PadW{1'b0}}, result};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  // The phase counter never runs past the last read phase.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase <= i2cbe_pkg::PHASE_W'(i2cbe_pkg::LAST_PHASE))
    else $error("phase counter out of range");

  // An idle sequencer always rests at phase zero.
  a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.active == i2cbe_pkg::CMD_NONE |-> state_r.phase == '0)
    else $error("idle sequencer with nonzero phase");

  // Bit counter stays within one byte.
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.bit_count <= i2cbe_pkg::BITCNT_W'(i2cbe_pkg::BITS_PER_BYTE))
    else $error("bit counter out of range");

  // While polling for the ACK there is always at least one poll left.
  a_polls_left: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.active == i2cbe_pkg::CMD_WRITE && state_r.phase == 4'd7
    |-> state_r.polls_left != 8'd0)
    else $error("ACK polling with no polls left");

  // A write accepted while idle clears the error flag on its first tick.
  a_write_clears_error: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && state_r.active == i2cbe_pkg::CMD_NONE &&
    in_tuser == i2cbe_pkg::CMD_WRITE |=> !state_r.error)
    else $error("error flag not cleared by a new write");

  // A done word never reports busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && result.done |=> !out_tdata_r[3])
    else $error("done reported together with busy");

endmodule

/* sv/i2cbe_seq.sv */
// One phase step of the I2C master pin sequencer: takes the current state and
// one tick's inputs and gives the next state and the tick's result.
// Depends on i2cbe_pkg.
module i2cbe_seq (
  input  i2cbe_pkg::seq_state_t state_cur,
  input  logic [2:0]            command,
  input  logic [7:0]            write_data,
  input  logic                  send_nack,
  input  logic                  sda_in,
  input  logic [7:0]            ack_timeout,
  output i2cbe_pkg::seq_state_t state_nxt,
  output i2cbe_pkg::result_t    result
);

  i2cbe_pkg::seq_state_t s;
  logic                  done;
  logic [i2cbe_pkg::BITCNT_W-1:0] cnt_inc;
  logic [7:0]            polls_dec;

  always_comb begin
    s    = state_cur;
    done = 1'b0;

    // A new command is taken only when the sequencer is idle.
    if (state_cur.active == i2cbe_pkg::CMD_NONE &&
        (command == i2cbe_pkg::CMD_START || command == i2cbe_pkg::CMD_STOP ||
         command == i2cbe_pkg::CMD_WRITE || command == i2cbe_pkg::CMD_READ)) begin
      s.active    = i2cbe_pkg::cmd_t'(command);
      s.phase     = '0;
      s.bit_count = '0;
      if (command == i2cbe_pkg::CMD_WRITE) begin
        s.shift_byte = write_data;
        s.error      = 1'b0;
      end else if (command == i2cbe_pkg::CMD_READ) begin
        s.shift_byte  = '0;
        s.nack_choice = send_nack;
      end
    end

    cnt_inc   = s.bit_count + 1'b1;
    polls_dec = s.polls_left - 8'd1;

    unique case (s.active)
      i2cbe_pkg::CMD_NONE: begin
      end
      i2cbe_pkg::CMD_START: begin
        unique case (s.phase)
          4'd0: begin s.sda_drive = 1'b1; s.sda_level = 1'b1; s.phase = 4'd1; end
          4'd1: begin s.scl = 1'b1; s.phase = 4'd2; end
          4'd2: begin s.sda_level = 1'b0; s.phase = 4'd3; end
          4'd3: begin
            s.scl = 1'b0; s.active = i2cbe_pkg::CMD_NONE; s.phase = '0; done = 1'b1;
          end
          default: begin s.active = i2cbe_pkg::CMD_NONE; s.phase = '0; end
        endcase
      end
      i2cbe_pkg::CMD_STOP: begin
        unique case (s.phase)
          4'd0: begin s.scl = 1'b0; s.phase = 4'd1; end
          4'd1: begin s.sda_drive = 1'b1; s.sda_level = 1'b0; s.phase = 4'd2; end
          4'd2: begin s.scl = 1'b1; s.phase = 4'd3; end
          4'd3: begin
            s.sda_level = 1'b1; s.active = i2cbe_pkg::CMD_NONE; s.phase = '0; done = 1'b1;
          end
          default: begin s.active = i2cbe_pkg::CMD_NONE; s.phase = '0; end
        endcase
      end
      i2cbe_pkg::CMD_WRITE: begin
        unique case (s.phase)
          4'd0: begin s.scl = 1'b0; s.phase = 4'd1; end
          4'd1: begin
            s.sda_drive = 1'b1; s.sda_level = s.shift_byte[7]; s.phase = 4'd2;
          end
          4'd2: begin s.shift_byte = {s.shift_byte[6:0], 1'b0}; s.phase = 4'd3; end
          4'd3: begin
            s.scl       = 1'b1;
            s.bit_count = cnt_inc;
            s.phase     = (cnt_inc >= i2cbe_pkg::BITCNT_W'(i2cbe_pkg::BITS_PER_BYTE))
                          ? 4'd4 : 4'd0;
          end
          4'd4: begin s.scl = 1'b0; s.phase = 4'd5; end
          4'd5: begin s.sda_drive = 1'b0; s.phase = 4'd6; end
          4'd6: begin
            s.scl        = 1'b1;
            s.polls_left = (ack_timeout == 8'd0) ? 8'd1 : ack_timeout;
            s.phase      = 4'd7;
          end
          4'd7: begin
            if (!sda_in) begin
              // Slave pulled SDA low: acknowledged.
              s.scl = 1'b0; s.sda_drive = 1'b1;
              s.active = i2cbe_pkg::CMD_NONE; s.phase = '0; done = 1'b1;
            end else begin
              s.polls_left = polls_dec;
              if (polls_dec == 8'd0) begin
                // Timed out: flag it and release the bus with a stop.
                s.sda_drive = 1'b1;
                s.error     = 1'b1;
                s.active    = i2cbe_pkg::CMD_STOP;
                s.phase     = '0;
              end
            end
          end
          default: begin s.active = i2cbe_pkg::CMD_NONE; s.phase = '0; end
        endcase
      end
      i2cbe_pkg::CMD_READ: begin
        unique case (s.phase)
          4'd0: begin s.sda_drive = 1'b0; s.scl = 1'b0; s.phase = 4'd1; end
          4'd1: begin s.phase = 4'd2; end
          4'd2: begin s.scl = 1'b1; s.phase = 4'd3; end
          4'd3: begin
            s.shift_byte = {s.shift_byte[6:0], sda_in};
            s.bit_count  = cnt_inc;
            s.phase      = (cnt_inc >= i2cbe_pkg::BITCNT_W'(i2cbe_pkg::BITS_PER_BYTE))
                           ? 4'd4 : 4'd0;
          end
          4'd4: begin s.scl = 1'b0; s.phase = 4'd5; end
          4'd5: begin s.sda_drive = 1'b1; s.sda_level = s.nack_choice; s.phase = 4'd6; end
          4'd6: begin s.phase = 4'd7; end
          4'd7: begin s.scl = 1'b1; s.phase = 4'd8; end
          4'd8: begin
            s.scl = 1'b0; s.active = i2cbe_pkg::CMD_NONE; s.phase = '0; done = 1'b1;
          end
          default: begin s.active = i2cbe_pkg::CMD_NONE; s.phase = '0; end
        endcase
      end
      default: begin s.active = i2cbe_pkg::CMD_NONE; s.phase = '0; end
    endcase

    state_nxt        = s;
    result.scl_level = s.scl;
    result.sda_drive = s.sda_drive;
    result.sda_level = s.sda_level;
    result.busy      = (s.active != i2cbe_pkg::CMD_NONE);
    result.done      = done;
    result.read_data = s.shift_byte;
    result.ack_error = s.error;
  end

endmodule

/* tb/i2c_master_bit_engine_unit_tb.sv */
// Testbench for i2c_master_bit_engine_unit: it drives pin ticks and commands,
// predicts every output word and checks each one as it arrives.
// Depends on i2cbe_pkg and the i2c_master_bit_engine_unit RTL.
`timescale 1ns / 1ps

module i2c_master_bit_engine_unit_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_TICKS = 110;

  // Tracks the sequencer tick by tick and holds the output words still due.
  class pin_tick_scoreboard;
    logic [7:0] ack_timeout;
    logic [2:0] op;
    logic [3:0] step;
    logic [3:0] bits_done;
    logic [7:0] shreg;
    logic       nack_reply;
    logic [7:0] polls;
    logic       scl;
    logic       sda_oe;
    logic       sda_out;
    logic       ack_err;
    i2cbe_pkg::result_t words_due[$];
    int unsigned errors, n_ticks, n_checked, n_timeouts;
    int unsigned n_start_done, n_stop_done, n_write_done, n_read_done;

    function void reset_state();
      ack_timeout = 8'(i2cbe_pkg::TIMEOUT_RESET);
      op = i2cbe_pkg::CMD_NONE;
      step = '0;
      bits_done = '0;
      shreg = '0;
      nack_reply = 1'b0;
      polls = '0;
      scl = 1'b1;
      sda_oe = 1'b1;
      sda_out = 1'b1;
      ack_err = 1'b0;
    endfunction

    function bit busy();
      return op != i2cbe_pkg::CMD_NONE;
    endfunction

    // Advance the predicted sequencer by one accepted tick and queue its word.
    function void note_tick(logic [2:0] cmd, logic [7:0] wdata, logic nack, logic sda);
      i2cbe_pkg::result_t r;
      logic    fin;
      fin = 1'b0;
      n_ticks++;
      if (op == i2cbe_pkg::CMD_NONE && cmd >= i2cbe_pkg::CMD_START &&
          cmd <= i2cbe_pkg::CMD_READ) begin
        op = cmd;
        step = '0;
        bits_done = '0;
        if (cmd == i2cbe_pkg::CMD_WRITE) begin
          shreg = wdata;
          ack_err = 1'b0;
        end else if (cmd == i2cbe_pkg::CMD_READ) begin
          shreg = '0;
          nack_reply = nack;
        end
      end
      case (op)
        i2cbe_pkg::CMD_NONE: ;
        i2cbe_pkg::CMD_START: begin
          case (step)
            0: begin sda_oe = 1'b1; sda_out = 1'b1; step = 4'd1; end
            1: begin scl = 1'b1; step = 4'd2; end
            2: begin sda_out = 1'b0; step = 4'd3; end
            3: begin scl = 1'b0; fin = 1'b1; end
            default: begin op = i2cbe_pkg::CMD_NONE; step = '0; end
          endcase
        end
        i2cbe_pkg::CMD_STOP: begin
          case (step)
            0: begin scl = 1'b0; step = 4'd1; end
            1: begin sda_oe = 1'b1; sda_out = 1'b0; step = 4'd2; end
            2: begin scl = 1'b1; step = 4'd3; end
            3: begin sda_out = 1'b1; fin = 1'b1; end
            default: begin op = i2cbe_pkg::CMD_NONE; step = '0; end
          endcase
        end
        i2cbe_pkg::CMD_WRITE: begin
          case (step)
            0: begin scl = 1'b0; step = 4'd1; end
            1: begin sda_oe = 1'b1; sda_out = shreg[7]; step = 4'd2; end
            2: begin shreg = {shreg[6:0], 1'b0}; step = 4'd3; end
            3: begin
              scl = 1'b1;
              bits_done = bits_done + 1'b1;
              step = (bits_done >= i2cbe_pkg::BITS_PER_BYTE) ? 4'd4 : 4'd0;
            end
            4: begin scl = 1'b0; step = 4'd5; end
            5: begin sda_oe = 1'b0; step = 4'd6; end
            6: begin
              scl = 1'b1;
              polls = (ack_timeout == 8'd0) ? 8'd1 : ack_timeout;
              step = 4'd7;
            end
            7: begin
              if (sda == 1'b0) begin
                scl = 1'b0;
                sda_oe = 1'b1;
                fin = 1'b1;
              end else begin
                polls = polls - 1'b1;
                // No ACK in time: flag it and fall into a stop sequence.
                if (polls == 8'd0) begin
                  sda_oe = 1'b1;
                  ack_err = 1'b1;
                  op = i2cbe_pkg::CMD_STOP;
                  step = '0;
                  n_timeouts++;
                end
              end
            end
            default: begin op = i2cbe_pkg::CMD_NONE; step = '0; end
          endcase
        end
        i2cbe_pkg::CMD_READ: begin
          case (step)
            0: begin sda_oe = 1'b0; scl = 1'b0; step = 4'd1; end
            1: step = 4'd2;
            2: begin scl = 1'b1; step = 4'd3; end
            3: begin
              shreg = {shreg[6:0], sda};
              bits_done = bits_done + 1'b1;
              step = (bits_done >= i2cbe_pkg::BITS_PER_BYTE) ? 4'd4 : 4'd0;
            end
            4: begin scl = 1'b0; step = 4'd5; end
            5: begin sda_oe = 1'b1; sda_out = nack_reply; step = 4'd6; end
            6: step = 4'd7;
            7: begin scl = 1'b1; step = 4'd8; end
            8: begin scl = 1'b0; fin = 1'b1; end
            default: begin op = i2cbe_pkg::CMD_NONE; step = '0; end
          endcase
        end
        default: begin op = i2cbe_pkg::CMD_NONE; step = '0; end
      endcase
      if (fin) begin
        case (op)
          i2cbe_pkg::CMD_START: n_start_done++;
          i2cbe_pkg::CMD_STOP:  n_stop_done++;
          i2cbe_pkg::CMD_WRITE: n_write_done++;
          i2cbe_pkg::CMD_READ:  n_read_done++;
          default: ;
        endcase
        op = i2cbe_pkg::CMD_NONE;
        step = '0;
      end
      r.scl_level = scl;
      r.sda_drive = sda_oe;
      r.sda_level = sda_out;
      r.busy      = (op != i2cbe_pkg::CMD_NONE);
      r.done      = fin;
      r.read_data = shreg;
      r.ack_error = ack_err;
      words_due.push_back(r);
    endfunction

    function void check_field(string field, int unsigned e, int unsigned a);
      if (e != a) begin
        $error("%s mismatch: expected %0h, actual %0h", field, e, a);
        errors++;
      end
    endfunction

    function void check_word(logic [i2cbe_pkg::OUT_TDATA_W-1:0] w);
      i2cbe_pkg::result_t e, a;
      if (words_due.size() == 0) begin
        $error("output word %h arrived with nothing due", w);
        errors++;
        return;
      end
      e = words_due.pop_front();
      a = w[13:0];
      n_checked++;
      check_field("scl_level", e.scl_level, a.scl_level);
      check_field("sda_drive", e.sda_drive, a.sda_drive);
      check_field("sda_level", e.sda_level, a.sda_level);
      check_field("busy_res",  e.busy,      a.busy);
      check_field("done_res",  e.done,      a.done);
      check_field("read_data", e.read_data, a.read_data);
      check_field("ack_error", e.ack_error, a.ack_error);
      check_field("zero fill", 0, w[15:14]);
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic [i2cbe_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [2:0]             in_tuser;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [i2cbe_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [i2cbe_pkg::CFG_ADDR_W-1:0]  cfg_paddr;
  logic [i2cbe_pkg::CFG_DATA_W-1:0]  cfg_pwdata;
  logic [i2cbe_pkg::CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  pin_tick_scoreboard sb;
  bit                 quiet;      // while set, neither side idles
  int unsigned        cycles;
  int unsigned        n_cfg_writes;

  i2c_master_bit_engine_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random back-pressure, and every accepted word is checked.
  // The ready seen at an edge was driven at the edge before, so the sample
  // never depends on the order of processes within the step.
  always @(posedge clk) begin
    out_tready <= quiet || ($urandom_range(99) >= 31);
    if (rst_n && out_tvalid && out_tready)
      sb.check_word(out_tdata);
  end

  // Drives one tick word and returns on the edge that accepts it. The random
  // idle cycles come before the word, so a valid that stays high for
  // back-to-back words is never dropped and raised in one step.
  task automatic send_tick(logic [2:0] cmd, logic [7:0] wdata, logic nack, logic sda);
    while (!quiet && $urandom_range(99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'b0, sda, nack, wdata};
    do @(posedge clk); while (!in_tready);
    sb.note_tick(cmd, wdata, nack, sda);
  endtask

  // Issues one command on an idle engine and keeps ticking until it is idle
  // again. ack_after is the number of polls answered high before the slave
  // pulls SDA low (negative: never). rx_byte is what the slave returns on a
  // read. With noisy set, stray commands arrive while busy and must be ignored.
  task automatic run_command(logic [2:0] cmd, logic [7:0] wdata, logic nack, int ack_after,
                             logic [7:0] rx_byte, bit noisy);
    int         polls_seen;
    logic       sda;
    logic [2:0] c;
    polls_seen = 0;
    send_tick(cmd, wdata, nack, 1'($urandom_range(1)));
    while (sb.busy()) begin
      if (sb.op == i2cbe_pkg::CMD_WRITE && sb.step == 4'd7) begin
        sda = (ack_after < 0) || (polls_seen < ack_after);
        polls_seen++;
      end else if (sb.op == i2cbe_pkg::CMD_READ && sb.step == 4'd3) begin
        sda = rx_byte[7 - int'(sb.bits_done)];
      end else begin
        sda = 1'($urandom_range(1));
      end
      c = (noisy && $urandom_range(3) == 0) ? 3'($urandom_range(7)) : i2cbe_pkg::CMD_NONE;
      send_tick(c, 8'($urandom), 1'($urandom_range(1)), sda);
    end
  endtask

  // Writes ack_timeout over the configuration port once the engine is idle
  // and every word it owes has been taken, then reads it back.
  task automatic cfg_write_timeout(logic [7:0] value);
    while (sb.busy())
      send_tick(i2cbe_pkg::CMD_NONE, 8'($urandom), 1'($urandom_range(1)),
                1'($urandom_range(1)));
    in_tvalid <= 1'b0;
    while (sb.words_due.size() != 0)
      @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= 3'(4 * int'(i2cbe_pkg::REG_ACK_TIMEOUT));
    cfg_pwdata  <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    // Read the register back with a fresh setup and access cycle.
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.check_field("ack_timeout", int'(value), cfg_prdata);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    sb.ack_timeout = value;
    n_cfg_writes++;
  endtask

  // One random command with random content, then a short, possibly empty, idle gap.
  // Most writes meet a slave that ACKs after zero to three high polls, a few get none.
  task automatic random_command();
    int unsigned pick;
    int          ack_after;
    logic [2:0]  cmd;
    pick = $urandom_range(99);
    if (pick < 20)      cmd = i2cbe_pkg::CMD_START;
    else if (pick < 40) cmd = i2cbe_pkg::CMD_STOP;
    else if (pick < 70) cmd = i2cbe_pkg::CMD_WRITE;
    else if (pick < 95) cmd = i2cbe_pkg::CMD_READ;
    else                cmd = 3'($urandom_range(7, 5));
    ack_after = ($urandom_range(19) == 0) ? -1 : int'($urandom_range(3));
    run_command(cmd, 8'($urandom), 1'($urandom_range(1)), ack_after, 8'($urandom),
                $urandom_range(99) < 30);
    repeat ($urandom_range(2))
      send_tick(i2cbe_pkg::CMD_NONE, 8'($urandom), 1'($urandom_range(1)),
                1'($urandom_range(1)));
  endtask

  initial begin
    logic [7:0]  settings[6];
    int unsigned base;
    sb = new();
    sb.reset_state();
    clk         = 1'b0;
    rst_n       = 1'b0;
    quiet       = 1'b0;
    cycles      = 0;
    n_cfg_writes = 0;
    in_tdata    = '0;
    in_tuser    = i2cbe_pkg::CMD_NONE;
    in_tvalid   = 1'b0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset timeout of five polls: each command, byte
    // extremes, an ACK on the first poll, a late ACK, a missing ACK, both
    // read answers, unknown command codes and commands given while busy.
    run_command(i2cbe_pkg::CMD_START, 8'h00, 1'b0, 0, 8'h00, 1'b0);
    run_command(i2cbe_pkg::CMD_WRITE, 8'hFF, 1'b0, 0, 8'h00, 1'b0);
    run_command(i2cbe_pkg::CMD_WRITE, 8'h00, 1'b1, -1, 8'h00, 1'b0);
    run_command(i2cbe_pkg::CMD_WRITE, 8'hA5, 1'b0, 4, 8'h00, 1'b0);
    run_command(i2cbe_pkg::CMD_READ, 8'h00, 1'b0, 0, 8'hFF, 1'b0);
    run_command(i2cbe_pkg::CMD_READ, 8'hFF, 1'b1, 0, 8'h00, 1'b0);
    run_command(i2cbe_pkg::CMD_STOP, 8'h00, 1'b0, 0, 8'h00, 1'b0);
    run_command(3'd5, 8'h5A, 1'b1, 0, 8'h00, 1'b0);
    run_command(3'd6, 8'hC3, 1'b0, 0, 8'h00, 1'b0);
    run_command(3'd7, 8'h3C, 1'b1, 0, 8'h00, 1'b0);
    run_command(i2cbe_pkg::CMD_START, 8'h00, 1'b0, 0, 8'h00, 1'b1);
    run_command(i2cbe_pkg::CMD_READ, 8'h00, 1'b1, 0, 8'h96, 1'b1);
    run_command(i2cbe_pkg::CMD_WRITE, 8'h69, 1'b0, 1, 8'h00, 1'b1);
    run_command(i2cbe_pkg::CMD_STOP, 8'h00, 1'b0, 0, 8'h00, 1'b1);

    // A zero timeout still allows exactly one poll.
    cfg_write_timeout(8'd0);
    run_command(i2cbe_pkg::CMD_WRITE, 8'h3C, 1'b0, -1, 8'h00, 1'b0);
    run_command(i2cbe_pkg::CMD_WRITE, 8'hC3, 1'b0, 0, 8'h00, 1'b0);

    // The longest timeout: an ACK on the very last poll, then none at all.
    cfg_write_timeout(8'd255);
    run_command(i2cbe_pkg::CMD_WRITE, 8'h81, 1'b0, 254, 8'h00, 1'b0);
    run_command(i2cbe_pkg::CMD_WRITE, 8'h7E, 1'b0, -1, 8'h00, 1'b0);

    // Random part in phases, each with its own timeout. Every change drains
    // the engine first, so the sender waits for all outstanding words. The
    // third phase runs with no idling on either side.
    settings[0] = 8'd1;
    settings[1] = 8'd255;
    settings[2] = 8'd0;
    settings[3] = 8'($urandom_range(16, 2));
    settings[4] = 8'd5;
    settings[5] = 8'($urandom_range(255, 1));
    base = sb.n_ticks;
    for (int ph = 0; ph < 6; ph++) begin
      cfg_write_timeout(settings[ph]);
      quiet = (ph == 2);
      while (sb.n_ticks < base + (ph + 1) * PHASE_TICKS)
        random_command();
    end
    quiet = 1'b0;

    in_tvalid <= 1'b0;
    while (sb.words_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.words_due.size() != 0) begin
      $error("%0d output words never arrived", sb.words_due.size());
      sb.errors++;
    end

    $display("Covered %0d ticks, %0d words checked, %0d timeout settings written.",
             sb.n_ticks, sb.n_checked, n_cfg_writes);
    $display("Completed %0d starts, %0d stops, %0d writes, %0d reads; %0d ACK timeouts.",
             sb.n_start_done, sb.n_stop_done, sb.n_write_done, sb.n_read_done,
             sb.n_timeouts);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
sv/i2cbe_pkg.sv
sv/i2cbe_seq.sv
sv/i2c_master_bit_engine_unit.sv
tb/i2c_master_bit_engine_unit_tb.sv
